### rtl/pcm_frame_format_downmix_top_defines.svh
// Assertion macros used by the checker file.
`ifndef PCM_FRAME_FORMAT_DOWNMIX_TOP_DEFINES_SVH
`define PCM_FRAME_FORMAT_DOWNMIX_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PFD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define PFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pfd_pkg.sv
// Shared types and constants of the PCM frame format and downmix block.
package pfd_pkg;
	localparam int unsigned WordW = 32;
	localparam int unsigned SampW = 16;
	localparam logic [0:0] RegInputIsFloat = 1'd0;
	localparam logic [0:0] RegMonoOutput   = 1'd1;
	localparam logic signed [15:0] S16Max = 16'sd32767;
	localparam logic signed [15:0] S16Min = -16'sd32768;
	localparam logic [14:0] Scale = 15'd32767;

	// Per-channel conversion result after the first stage.
	typedef struct packed {
		logic        zero;
		logic        sat;
		logic        neg;
		logic [7:0]  expo;
		logic [23:0] mant;
	} fdec_t;
endpackage

### rtl/pfd_conv.sv
// One channel of sample conversion: float decode, scale, round, truncate, or integer pass-through.
module pfd_conv (
	input  logic        clk,
	input  logic        en,
	input  logic        is_float,
	input  logic [31:0] word,
	output logic signed [15:0] sample
);
	pfd_pkg::fdec_t d_s1;
	logic        isf_s1;
	logic [15:0] raw_s1;
	logic [38:0] prod_s2;
	logic        isf_s2;
	logic        zero_s2;
	logic        sat_s2;
	logic        neg_s2;
	logic [7:0]  expo_s2;
	logic [15:0] raw_s2;
	logic [5:0]  lz;
	logic [38:0] norm;
	logic [24:0] keep;
	logic        rbit;
	logic        sticky;
	logic [24:0] rnd;
	logic [8:0]  e2;
	logic [7:0]  sh;
	logic [15:0] mag;
	logic signed [15:0] conv;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1.neg  <= word[31];
			d_s1.expo <= word[30:23];
			d_s1.mant <= {1'b1, word[22:0]};
			d_s1.zero <= (word[30:23] == 8'd0) || (word[30:23] == 8'hFF && word[22:0] != 23'd0);
			d_s1.sat  <= word[30:23] >= 8'd127;
			isf_s1    <= is_float;
			raw_s1    <= word[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= d_s1.mant * pfd_pkg::Scale;
			isf_s2  <= isf_s1;
			zero_s2 <= d_s1.zero;
			sat_s2  <= d_s1.sat;
			neg_s2  <= d_s1.neg;
			expo_s2 <= d_s1.expo;
			raw_s2  <= raw_s1;
		end
	end

	// Product of two normalized mantissas has its top one at bit 38 or 37.
	always_comb begin
		lz     = prod_s2[38] ? 6'd0 : 6'd1;
		norm   = prod_s2 << lz;
		keep   = {1'b0, norm[38:15]};
		rbit   = norm[14];
		sticky = |norm[13:0];
		rnd    = keep + {24'd0, rbit & (sticky | keep[0])};
		// Value = rnd * 2^(e2 - 150); a rounding carry stays inside rnd.
		e2     = {1'b0, expo_s2} + 9'd15 - {3'd0, lz};
		sh     = 8'(9'd150 - e2);
		mag = (sh >= 8'd25) ? 16'd0 : 16'(rnd >> sh);
		if (!isf_s2) begin
			conv = $signed(raw_s2);
		end else if (zero_s2) begin
			conv = '0;
		end else if (sat_s2) begin
			conv = neg_s2 ? pfd_pkg::S16Min : pfd_pkg::S16Max;
		end else begin
			conv = neg_s2 ? -$signed(mag) : $signed(mag);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample <= conv;
		end
	end
endmodule

### rtl/pcm_frame_format_downmix_top.sv
// Top level of the PCM frame format converter with mono downmix.
// channel     | dir | content
// s_axis      | in  | tdata {right_word, left_word}, tuser end_of_period
// m_axis      | out | tdata {right_sample, left_sample}, tuser last_frame
// cfg         | in  | cfg_we, cfg_idx, cfg_data
// Four register stages; one frame per cycle while the output is not stalled.
// The pipeline advances whenever the output register is empty or taken.
// Reset clears the valid bits and sets integer input and mono; a stall freezes every stage.
module pcm_frame_format_downmix_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // left_word[31:0], right_word[63:32]
	input  logic        s_axis_tuser,   // end_of_period
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // left_sample[15:0], right_sample[31:16]
	output logic        m_axis_tuser,   // last_frame
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic        cfg_data
);
	logic isf_q, mono_q, en;
	logic [2:0] v_q;
	logic [2:0] eop_q;
	logic [2:0] mono_p_q;
	logic signed [15:0] l_c, r_c;
	logic signed [16:0] sum;
	logic signed [15:0] avg;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isf_q  <= 1'b0;
			mono_q <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_idx == pfd_pkg::RegInputIsFloat) isf_q <= cfg_data;
			if (cfg_idx == pfd_pkg::RegMonoOutput) mono_q <= cfg_data;
		end
	end

	pfd_conv u_l (.clk, .en, .is_float(isf_q), .word(s_axis_tdata[31:0]), .sample(l_c));
	pfd_conv u_r (.clk, .en, .is_float(isf_q), .word(s_axis_tdata[63:32]), .sample(r_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			v_q <= {v_q[1:0], s_axis_tvalid};
			m_axis_tvalid <= v_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eop_q    <= {eop_q[1:0], s_axis_tuser};
			mono_p_q <= {mono_p_q[1:0], mono_q};
		end
	end

	// Halving toward zero: add one to a negative sum before the shift.
	always_comb begin
		sum = 17'(l_c) + 17'(r_c);
		avg = 16'((sum + 17'(sum[16])) >>> 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tuser <= eop_q[2];
			m_axis_tdata <= mono_p_q[2] ? {avg, avg} : {r_c, l_c};
		end
	end
endmodule

### rtl/pfd_checker.sv
// Port-level checker for the PCM frame format converter, with its bind.
`include "pcm_frame_format_downmix_top_defines.svh"
module pfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser
);
	`PFD_ASSERT_IMP(a_ready_flow, !m_axis_tvalid || m_axis_tready, s_axis_tready, "stall without cause")
	`PFD_ASSERT_IMP(a_ready_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "accept while stalled")
	`PFD_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output changed while stalled")
endmodule

bind pcm_frame_format_downmix_top pfd_checker u_chk (.*);

### bench/tb_pcm_frame_format_downmix_top.sv
// Self-checking testbench for the PCM frame format converter with mono downmix.
`timescale 1ns / 1ps

class pcm_scoreboard;
	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               last;
	} pcm_frame_t;

	pcm_frame_t pending[$];
	bit         is_float = 1'b0;
	bit         mono     = 1'b1;
	int         errors   = 0;

	// Scale a single-precision word by 32767 with one rounding to single
	// precision, then truncate toward zero; saturate outside (-1, 1); NaN, zero and denormals give 0.
	static function int float_to_pcm(logic [31:0] w);
		int          e;
		logic [22:0] f;
		logic [63:0] p, r, rem, half;
		int          s, mag;
		e = int'(w[30:23]);
		f = w[22:0];
		if (e == 255 && f != 0)
			return 0;
		if (e == 0)
			return 0;
		if (e >= 127)
			return w[31] ? -32768 : 32767;
		p = {40'd0, 1'b1, f} * 64'd32767;
		s = (p[38] ? 38 : 37) - 23;
		r = p >> s;
		rem = p & ((64'd1 << s) - 1);
		half = 64'd1 << (s - 1);
		if (rem > half || (rem == half && r[0]))
			r = r + 1;
		if (r[24]) begin
			r = r >> 1;
			s = s + 1;
		end
		mag = int'(r >> (150 - s - e));
		return w[31] ? -mag : mag;
	endfunction

	function int word_to_pcm(logic [31:0] w);
		if (is_float)
			return float_to_pcm(w);
		return int'($signed(w[15:0]));
	endfunction

	function void note_frame(logic [31:0] lw, logic [31:0] rw, logic eop);
		pcm_frame_t fr;
		int         l, r;
		l = word_to_pcm(lw);
		r = word_to_pcm(rw);
		if (mono) begin
			l = (l + r) / 2;
			r = l;
		end
		fr.left = l[15:0];
		fr.right = r[15:0];
		fr.last = eop;
		pending.push_back(fr);
	endfunction

	function void check_frame(logic [31:0] data, logic user);
		pcm_frame_t fr;
		if (pending.size() == 0) begin
			$display("%0t: unexpected transfer data=%h last=%b", $time, data, user);
			errors++;
			return;
		end
		fr = pending.pop_front();
		if (data[15:0] !== fr.left) begin
			$display("%0t: left_sample expected %h actual %h", $time, fr.left, data[15:0]);
			errors++;
		end
		if (data[31:16] !== fr.right) begin
			$display("%0t: right_sample expected %h actual %h", $time, fr.right,
				data[31:16]);
			errors++;
		end
		if (user !== fr.last) begin
			$display("%0t: last_frame expected %b actual %b", $time, fr.last, user);
			errors++;
		end
	endfunction
endclass

module tb_pcm_frame_format_downmix_top;
	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_we;
	logic        cfg_idx;
	logic        cfg_data;

	pcm_scoreboard sb;
	bit            no_idle;
	int            hold_req;
	int            quiet_cycles;

	pcm_frame_format_downmix_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random back-pressure plus a long hold-off on request.
	initial begin
		int hold;
		hold = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold = hold_req;
				hold_req = 0;
			end
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= no_idle || ($urandom_range(99) >= 37);
			end
		end
	end

	// Note accepted inputs, check accepted outputs, and watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_frame(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_frame(m_axis_tdata, m_axis_tuser);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles > 5000) begin
				$display("[pcm_frame_format_downmix_top] ERROR");
				$finish;
			end
		end
	end

	task automatic send_frame(logic [31:0] lw, logic [31:0] rw, logic eop);
		if (!no_idle && $urandom_range(99) < 37) begin
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < 37);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {rw, lw};
		s_axis_tuser <= eop;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Drop valid and wait until every expected transfer has come out.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == pfd_pkg::RegInputIsFloat)
			sb.is_float = val;
		else
			sb.mono = val;
		@(posedge clk);
	endtask

	task automatic set_mode(logic fmode, logic mmode);
		drain();
		write_reg(pfd_pkg::RegInputIsFloat, fmode);
		write_reg(pfd_pkg::RegMonoOutput, mmode);
	endtask

	function automatic logic [31:0] rand_float();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: w[30:23] = 8'($urandom_range(126, 100));
			5: w[30:23] = 8'($urandom_range(126, 1));
			6: w[30:23] = 8'($urandom_range(130, 127));
			7: w[30:23] = 8'hFF;
			8: w[30:23] = 8'h00;
			default: ;
		endcase
		return w;
	endfunction

	task automatic random_frames(int n);
		for (int i = 0; i < n; i++) begin
			if (sb.is_float)
				send_frame(rand_float(), rand_float(), 1'($urandom));
			else
				send_frame($urandom, $urandom, 1'($urandom));
		end
	endtask

	logic [31:0] float_cases[14] = '{
		32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000,
		32'h7FC0_0001, 32'hFF80_0001, 32'h0000_0001, 32'h8000_0000,
		32'h3F7F_FFFF, 32'hBF7F_FFFF, 32'h3F00_0000, 32'hBEFF_FFFF,
		32'h0080_0000, 32'h3880_0001
	};

	initial begin
		sb = new();
		no_idle = 1'b0;
		hold_req = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = 1'b0;
		cfg_data = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset mode: integer input, mono. Extremes and ignored upper bits.
		send_frame(32'h0000_7FFF, 32'h0000_7FFF, 1'b0);
		send_frame(32'hFFFF_8000, 32'h0000_8000, 1'b1);
		send_frame(32'h0000_7FFF, 32'h0000_8000, 1'b0);
		send_frame(32'hABCD_0001, 32'h1234_FFFF, 1'b1);
		send_frame(32'h0000_FFFF, 32'hFFFF_FFFE, 1'b0);
		set_mode(1'b0, 1'b0);
		send_frame(32'h5A5A_8000, 32'hA5A5_7FFF, 1'b1);
		set_mode(1'b1, 1'b0);
		for (int i = 0; i < 14; i += 2)
			send_frame(float_cases[i], float_cases[i + 1], 1'(i));
		set_mode(1'b1, 1'b1);
		send_frame(32'h3F80_0000, 32'hBF80_0000, 1'b0);
		send_frame(32'hBF7F_FFFF, 32'hBF7F_FFFF, 1'b1);
		send_frame(32'h7FC0_0000, 32'h3F7F_FFFF, 1'b0);

		// Random phases over every mode; one stretch runs without idling and
		// one has the receiver hold off while frames keep coming.
		random_frames(200);
		set_mode(1'b0, 1'b1);
		random_frames(150);
		set_mode(1'b1, 1'b0);
		no_idle = 1'b1;
		random_frames(150);
		no_idle = 1'b0;
		hold_req = 200;
		random_frames(150);
		set_mode(1'b0, 1'b0);
		random_frames(150);
		set_mode(1'b1, 1'b1);
		random_frames(250);
		set_mode(1'b0, 1'b1);
		random_frames(150);

		drain();
		if (sb.errors == 0)
			$display("[pcm_frame_format_downmix_top] OK");
		else
			$display("[pcm_frame_format_downmix_top] ERROR");
		$finish;
	end
endmodule
